// ----- hw/rtl/touch_controller_command_handler_core_assert.svh -----
// Assertion macros shared by the checker files of the touch command handler.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef TOUCH_CONTROLLER_COMMAND_HANDLER_CORE_ASSERT_SVH
`define TOUCH_CONTROLLER_COMMAND_HANDLER_CORE_ASSERT_SVH

// same-cycle implication
`define TCCH_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TCCH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/tcch_pkg.sv -----
// Package of the touch command handler: opcodes, packet kinds, error codes,
// item and packet structs. Used by every RTL file of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcch_pkg;

	localparam int ERROR_SLOT_COUNT = 4;
	localparam int ERR_PAD_COUNT = (ERROR_SLOT_COUNT > 4) ? ERROR_SLOT_COUNT : 4;

	typedef enum logic [3:0] {
		OP_OPEN        = 4'd0,
		OP_QUERY_ACK   = 4'd1,
		OP_RESET       = 4'd2,
		OP_QUERY_PARAM = 4'd3,
		OP_SET_PARAM   = 4'd4,
		OP_SET_ACK     = 4'd5,
		OP_QUERY_RESET = 4'd6,
		OP_UNKNOWN     = 4'd7,
		OP_BAD_CSUM    = 4'd8,
		OP_TOUCH       = 4'd9
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_ACK   = 2'd0,
		KIND_RESET = 2'd1,
		KIND_PARAM = 2'd2,
		KIND_TOUCH = 2'd3
	} pkt_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE          = 3'd0,
		ERR_BAD_PACKET    = 3'd1,
		ERR_BAD_CHECKSUM  = 3'd2,
		ERR_ILLEGAL_CMD   = 3'd3,
		ERR_BAD_SERIAL    = 3'd4,
		ERR_SET_UNAVAIL   = 3'd5,
		ERR_QUERY_UNAVAIL = 3'd6
	} err_code_t;

	typedef enum logic [1:0] {
		TOUCH_NONE    = 2'd0,
		TOUCH_DOWN    = 2'd1,
		TOUCH_STREAM  = 2'd2,
		TOUCH_LIFTOFF = 2'd3
	} touch_kind_t;

	localparam logic [7:0] HARD_RESET_CODE = 8'h30;
	localparam logic [7:0] IO_MODE_SERIAL  = 8'h30;
	localparam logic [2:0] RATE_CODE_4800  = 3'b101;
	localparam logic [7:0] SER2_HANDSHAKE  = 8'b0000_0100;
	localparam logic [7:0] SER2_RESERVED   = 8'b0111_0000;
	localparam logic [1:0] RATE_9600       = 2'd1;
	localparam logic [7:0] STATUS_BASE     = 8'h80;
	localparam logic [7:0] STATUS_ERRPEND  = 8'h10;
	localparam logic [7:0] TOUCH_ID_MAIN   = 8'd1;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [7:0]  reset_kind;
		logic [7:0]  io_mode;
		logic [7:0]  serial_one;
		logic [7:0]  serial_two;
		logic [1:0]  touch_kind;
		logic [7:0]  touch_id;
		logic [11:0] x_pos;
		logic [11:0] y_pos;
	} item_t;

	typedef struct packed {
		pkt_kind_t       kind;
		logic [7:0]      status;
		logic [11:0]     x;
		logic [11:0]     y;
		logic [3:0][2:0] err;
		logic [1:0]      rate;
		logic            hs;
		logic            last;
	} pkt_t;

	// results of one item, at most two packets
	typedef struct packed {
		logic [1:0] n;
		pkt_t       p0;
		pkt_t       p1;
	} res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tcch_in_reg.sv -----
// Input register stage of the touch command handler.
// Depends on tcch_pkg for the item struct.
`timescale 1ns / 1ps
`default_nettype none

module tcch_in_reg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire tcch_pkg::item_t item,
	input  wire logic           advance,
	output logic                in_stall,
	output logic                valid_s1,
	output tcch_pkg::item_t     item_s1
);

	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= item;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/tcch_exec.sv -----
// Command and touch execution: controller state and result packet build.
// Depends on tcch_pkg for opcodes, error codes and packet structs.
`timescale 1ns / 1ps
`default_nettype none

module tcch_exec (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tcch_pkg::item_t item_s1,
	input  wire logic            fire,
	output tcch_pkg::res_t       res
);

	logic [2:0] slot_q [tcch_pkg::ERROR_SLOT_COUNT];
	logic [2:0] slot_n [tcch_pkg::ERROR_SLOT_COUNT];
	logic       pend_q, pend_n;
	logic       rep_q, rep_n;
	logic [1:0] rate_q, rate_n;
	logic       hs_q, hs_n;

	logic                 err_en;
	tcch_pkg::err_code_t  err_code;
	logic                 found;
	logic [1:0]           n_res;
	tcch_pkg::pkt_kind_t  kind0;
	logic                 with_err0;
	logic [7:0]           status;
	logic [2:0]           rate_code;
	logic [2:0]           rate_diff;
	logic                 ser_ok;
	logic [2:0]           err_pad [tcch_pkg::ERR_PAD_COUNT];
	logic [3:0][2:0]      err_vec;
	tcch_pkg::pkt_t       base_pkt;

	assign rate_code = item_s1.serial_one[2:0];
	assign rate_diff = rate_code - tcch_pkg::RATE_CODE_4800;
	assign ser_ok    = (item_s1.io_mode == tcch_pkg::IO_MODE_SERIAL) &&
	                   (rate_code >= tcch_pkg::RATE_CODE_4800);

	always_comb begin
		for (int i = 0; i < tcch_pkg::ERROR_SLOT_COUNT; i++) slot_n[i] = slot_q[i];
		pend_n    = pend_q;
		rep_n     = rep_q;
		rate_n    = rate_q;
		hs_n      = hs_q;
		err_en    = 1'b0;
		err_code  = tcch_pkg::ERR_NONE;
		n_res     = 2'd0;
		kind0     = tcch_pkg::KIND_ACK;
		with_err0 = 1'b0;
		status    = '0;

		unique case (item_s1.opcode)
			tcch_pkg::OP_OPEN: begin
				rep_n = 1'b1;
			end
			tcch_pkg::OP_QUERY_ACK: begin
				n_res     = 2'd1;
				with_err0 = 1'b1;
				rep_n     = 1'b1;
			end
			tcch_pkg::OP_RESET: begin
				if (item_s1.reset_kind == tcch_pkg::HARD_RESET_CODE) begin
					for (int i = 0; i < tcch_pkg::ERROR_SLOT_COUNT; i++) slot_n[i] = '0;
				end else begin
					n_res = 2'd1;
					kind0 = tcch_pkg::KIND_RESET;
				end
				rep_n = 1'b1;
			end
			tcch_pkg::OP_QUERY_PARAM: begin
				n_res = 2'd2;
				kind0 = tcch_pkg::KIND_PARAM;
				rep_n = 1'b1;
			end
			tcch_pkg::OP_SET_PARAM: begin
				n_res     = 2'd1;
				with_err0 = 1'b1;
				if (!ser_ok) begin
					err_en   = 1'b1;
					err_code = tcch_pkg::ERR_BAD_SERIAL;
				end else begin
					rate_n = rate_diff[1:0];
					if ((item_s1.serial_two & tcch_pkg::SER2_HANDSHAKE) != '0) hs_n = 1'b1;
					if ((item_s1.serial_two & tcch_pkg::SER2_RESERVED) != '0) begin
						err_en   = 1'b1;
						err_code = tcch_pkg::ERR_BAD_PACKET;
					end else begin
						rep_n = 1'b1;
					end
				end
			end
			tcch_pkg::OP_SET_ACK: begin
				err_en   = 1'b1;
				err_code = tcch_pkg::ERR_SET_UNAVAIL;
			end
			tcch_pkg::OP_QUERY_RESET: begin
				err_en   = 1'b1;
				err_code = tcch_pkg::ERR_QUERY_UNAVAIL;
			end
			tcch_pkg::OP_BAD_CSUM: begin
				err_en   = 1'b1;
				err_code = tcch_pkg::ERR_BAD_CHECKSUM;
			end
			tcch_pkg::OP_TOUCH: begin
				if (rep_q && item_s1.touch_kind != tcch_pkg::TOUCH_NONE &&
				    item_s1.touch_id == tcch_pkg::TOUCH_ID_MAIN) begin
					n_res = 2'd1;
					kind0 = tcch_pkg::KIND_TOUCH;
					unique case (item_s1.touch_kind)
						tcch_pkg::TOUCH_DOWN:   status = tcch_pkg::STATUS_BASE | 8'h01;
						tcch_pkg::TOUCH_STREAM: status = tcch_pkg::STATUS_BASE | 8'h02;
						default:                status = tcch_pkg::STATUS_BASE | 8'h04;
					endcase
					if (pend_q) status = status | tcch_pkg::STATUS_ERRPEND;
					pend_n = 1'b0;
				end
			end
			default: begin
				// unknown command and undefined opcodes
				err_en   = 1'b1;
				err_code = tcch_pkg::ERR_ILLEGAL_CMD;
				rep_n    = 1'b1;
			end
		endcase

		// first empty slot takes the error, slot 0 when all are full
		found = 1'b0;
		if (err_en) begin
			for (int i = 0; i < tcch_pkg::ERROR_SLOT_COUNT; i++) begin
				if (!found && slot_n[i] == tcch_pkg::ERR_NONE) begin
					slot_n[i] = err_code;
					found     = 1'b1;
				end
			end
			if (!found) slot_n[0] = err_code;
			pend_n = 1'b1;
		end
	end

	always_comb begin
		for (int i = 0; i < tcch_pkg::ERR_PAD_COUNT; i++) err_pad[i] = '0;
		for (int i = 0; i < tcch_pkg::ERROR_SLOT_COUNT; i++) err_pad[i] = slot_n[i];
		for (int i = 0; i < 4; i++) err_vec[i] = err_pad[i];
	end

	always_comb begin
		base_pkt      = '0;
		base_pkt.kind = tcch_pkg::KIND_ACK;
		base_pkt.rate = rate_n;
		base_pkt.hs   = hs_n;

		res.n = n_res;

		res.p0        = base_pkt;
		res.p0.kind   = kind0;
		res.p0.status = status;
		res.p0.last   = (n_res == 2'd1);
		if (kind0 == tcch_pkg::KIND_TOUCH) begin
			res.p0.x = item_s1.x_pos;
			res.p0.y = item_s1.y_pos;
		end
		if (with_err0) res.p0.err = err_vec;

		// second packet only follows a parameter reply
		res.p1      = base_pkt;
		res.p1.err  = err_vec;
		res.p1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tcch_pkg::ERROR_SLOT_COUNT; i++) slot_q[i] <= '0;
			pend_q <= 1'b0;
			rep_q  <= 1'b0;
			rate_q <= tcch_pkg::RATE_9600;
			hs_q   <= 1'b0;
		end else if (fire) begin
			for (int i = 0; i < tcch_pkg::ERROR_SLOT_COUNT; i++) slot_q[i] <= slot_n[i];
			pend_q <= pend_n;
			rep_q  <= rep_n;
			rate_q <= rate_n;
			hs_q   <= hs_n;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/tcch_out_buf.sv -----
// Two-entry result buffer of the touch command handler; entry 0 drives the port.
// Depends on tcch_pkg for the packet structs.
`timescale 1ns / 1ps
`default_nettype none

module tcch_out_buf (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire tcch_pkg::res_t res,
	input  wire logic           out_stall,
	output logic [1:0]          free,
	output logic                out_valid,
	output tcch_pkg::pkt_t      head
);

	tcch_pkg::pkt_t ent_q [2];
	tcch_pkg::pkt_t ent_n [2];
	tcch_pkg::pkt_t kept;
	logic [1:0]     cnt_q, cnt_n;
	logic [1:0]     base;
	logic           pop;

	assign out_valid = (cnt_q != 2'd0);
	assign head      = ent_q[0];
	assign pop       = out_valid && !out_stall;
	assign base      = cnt_q - {1'b0, pop};
	assign free      = 2'd2 - base;

	always_comb begin
		kept     = pop ? ent_q[1] : ent_q[0];
		ent_n[0] = ent_q[0];
		ent_n[1] = ent_q[1];
		cnt_n    = base;
		if (push) cnt_n = base + res.n;
		unique case (base)
			2'd0: begin
				ent_n[0] = res.p0;
				ent_n[1] = res.p1;
			end
			2'd1: begin
				ent_n[0] = kept;
				ent_n[1] = res.p0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		ent_q[0] <= ent_n[0];
		ent_q[1] <= ent_n[1];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/touch_controller_command_handler_core.sv -----
// Touch command handler top level: input register, execution stage, result buffer.
// Depends on tcch_pkg, tcch_in_reg, tcch_exec and tcch_out_buf.
//
// One transaction is taken per cycle while in_stall is low. Each item is
// registered in the input register, executed from there against the controller
// state, and its zero, one or two result packets land in a two-entry output
// buffer, which is registered and drives the port. A query param yields a
// parameter reply and an acknowledge. An item leaves the input register only
// when the buffer has room for all its packets. in_stall follows out_stall
// combinationally through that room check.
`timescale 1ns / 1ps
`default_nettype none

module touch_controller_command_handler_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [3:0]  opcode,
	input  wire logic [7:0]  reset_kind,
	input  wire logic [7:0]  io_mode,
	input  wire logic [7:0]  serial_one,
	input  wire logic [7:0]  serial_two,
	input  wire logic [1:0]  touch_kind,
	input  wire logic [7:0]  touch_id,
	input  wire logic [15:0] x_position,
	input  wire logic [15:0] y_position,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       packet_kind,
	output logic [7:0]       status_byte,
	output logic [11:0]      x_out,
	output logic [11:0]      y_out,
	output logic [2:0]       error_zero,
	output logic [2:0]       error_one,
	output logic [2:0]       error_two,
	output logic [2:0]       error_three,
	output logic [1:0]       rate_select,
	output logic             handshake_on,
	output logic             last
);

	tcch_pkg::item_t item;
	tcch_pkg::item_t item_s1;
	tcch_pkg::res_t  res;
	tcch_pkg::pkt_t  head;
	logic            valid_s1;
	logic            fire;
	logic [1:0]      free;

	always_comb begin
		item.opcode     = opcode;
		item.reset_kind = reset_kind;
		item.io_mode    = io_mode;
		item.serial_one = serial_one;
		item.serial_two = serial_two;
		item.touch_kind = touch_kind;
		item.touch_id   = touch_id;
		item.x_pos      = x_position[11:0];
		item.y_pos      = y_position[11:0];
	end

	// item moves on only if all of its packets fit
	assign fire = valid_s1 && (res.n <= free);

	tcch_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.item     (item),
		.advance  (fire),
		.in_stall (in_stall),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	tcch_exec u_exec (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_s1 (item_s1),
		.fire    (fire),
		.res     (res)
	);

	tcch_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.res       (res),
		.out_stall (out_stall),
		.free      (free),
		.out_valid (out_valid),
		.head      (head)
	);

	assign packet_kind  = head.kind;
	assign status_byte  = head.status;
	assign x_out        = head.x;
	assign y_out        = head.y;
	assign error_zero   = head.err[0];
	assign error_one    = head.err[1];
	assign error_two    = head.err[2];
	assign error_three  = head.err[3];
	assign rate_select  = head.rate;
	assign handshake_on = head.hs;
	assign last         = head.last;

endmodule

`default_nettype wire

// ----- hw/rtl/tcch_checker.sv -----
// Port-level checks of the touch command handler, bound to the top level.
// Depends on tcch_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "touch_controller_command_handler_core_assert.svh"

module tcch_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  packet_kind,
	input wire logic [7:0]  status_byte,
	input wire logic [11:0] x_out,
	input wire logic [11:0] y_out,
	input wire logic [2:0]  error_zero,
	input wire logic [2:0]  error_one,
	input wire logic [2:0]  error_two,
	input wire logic [2:0]  error_three,
	input wire logic [1:0]  rate_select,
	input wire logic        last
);

	logic non_ack;
	logic non_touch;
	logic no_err;
	logic no_touch;
	logic last_ok;

	assign non_ack   = out_valid && (packet_kind != tcch_pkg::KIND_ACK);
	assign non_touch = out_valid && (packet_kind != tcch_pkg::KIND_TOUCH);
	assign no_err    = (error_zero == 3'd0) && (error_one == 3'd0) &&
	                   (error_two == 3'd0) && (error_three == 3'd0);
	assign no_touch  = (status_byte == 8'd0) && (x_out == 12'd0) && (y_out == 12'd0);
	// a parameter reply is always followed by an acknowledge; others end the transaction
	assign last_ok   = (packet_kind == tcch_pkg::KIND_PARAM) ? !last :
	                   ((packet_kind == tcch_pkg::KIND_ACK) || last);

	`TCCH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")

	// only acknowledges carry error slots
	`TCCH_ASSERT(a_err_ack_only, non_ack, no_err, "error slots outside acknowledge")

	// coordinates and status only in touch reports
	`TCCH_ASSERT(a_touch_only, non_touch, no_touch, "touch fields outside report")

	`TCCH_ASSERT(a_last_flag, out_valid, last_ok, "last flag wrong for packet kind")

	`TCCH_ASSERT(a_rate_range, out_valid, rate_select != 2'd3, "line rate out of range")

endmodule

bind touch_controller_command_handler_core tcch_checker u_tcch_checker (.*);

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking bench for touch_controller_command_handler_core: directed table, then random
// commands and touches checked against a behavioral model of the controller state.
// Depends on tcch_pkg for opcodes, packet kinds, error codes and packet layout.
`timescale 1ns / 1ps

module tb;
	import tcch_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_ITEMS = 750;
	localparam int HOLD_LEN = 300;
	localparam int DRAIN_LIMIT = 5000;
	localparam int TAIL_CYCLES = 16;
	localparam int MAX_PRINTS = 40;

	localparam logic [3:0] OP_FIRST_UNDEF = 4'hA;
	localparam logic [3:0] OP_LAST_UNDEF = 4'hF;
	localparam logic [1:0] RATE_4800 = 2'd0;
	localparam logic [1:0] RATE_19200 = 2'd2;

	typedef struct packed {
		logic [3:0]  op;
		logic [7:0]  reset_kind;
		logic [7:0]  io_mode;
		logic [7:0]  ser1;
		logic [7:0]  ser2;
		logic [1:0]  tkind;
		logic [7:0]  tid;
		logic [15:0] x;
		logic [15:0] y;
	} cmd_t;

	// typed rows carry their own expected reply; the rest go through the model
	typedef struct {
		cmd_t c;
		bit   typed;
		int   typed_n;
		pkt_t typed_pkt;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [3:0]  opcode;
	logic [7:0]  reset_kind;
	logic [7:0]  io_mode;
	logic [7:0]  serial_one;
	logic [7:0]  serial_two;
	logic [1:0]  touch_kind;
	logic [7:0]  touch_id;
	logic [15:0] x_position;
	logic [15:0] y_position;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  packet_kind;
	logic [7:0]  status_byte;
	logic [11:0] x_out;
	logic [11:0] y_out;
	logic [2:0]  error_zero;
	logic [2:0]  error_one;
	logic [2:0]  error_two;
	logic [2:0]  error_three;
	logic [1:0]  rate_select;
	logic        handshake_on;
	logic        last;

	// model copy of the controller state
	err_code_t  err_slot [ERR_PAD_COUNT];
	logic       err_pend;
	logic       rpt_en;
	logic [1:0] line_rate;
	logic       hs_state;

	pkt_t reply_q [$];
	row_t dir_rows [$];
	int   fail_cnt = 0;

	touch_controller_command_handler_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.reset_kind   (reset_kind),
		.io_mode      (io_mode),
		.serial_one   (serial_one),
		.serial_two   (serial_two),
		.touch_kind   (touch_kind),
		.touch_id     (touch_id),
		.x_position   (x_position),
		.y_position   (y_position),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.packet_kind  (packet_kind),
		.status_byte  (status_byte),
		.x_out        (x_out),
		.y_out        (y_out),
		.error_zero   (error_zero),
		.error_one    (error_one),
		.error_two    (error_two),
		.error_three  (error_three),
		.rate_select  (rate_select),
		.handshake_on (handshake_on),
		.last         (last)
	);

	always #4 clk = ~clk;

	task automatic flag_mismatch(input string what, input logic [11:0] got,
		input logic [11:0] want);
		if (fail_cnt < MAX_PRINTS) begin
			$display("%0t ns: %s: got %0h expected %0h", $time, what, got, want);
		end
		fail_cnt++;
	endtask

	task automatic cmp_field(input string what, input logic [11:0] got, input logic [11:0] want);
		if (got !== want) begin
			flag_mismatch(what, got, want);
		end
	endtask

	function automatic pkt_t mk_pkt(input pkt_kind_t k, input logic [7:0] st,
		input logic [11:0] x, input logic [11:0] y, input err_code_t e0, input err_code_t e1,
		input err_code_t e2, input err_code_t e3, input logic [1:0] rate, input logic hs,
		input logic lst);
		pkt_t p;
		p.kind = k;
		p.status = st;
		p.x = x;
		p.y = y;
		p.err[0] = e0;
		p.err[1] = e1;
		p.err[2] = e2;
		p.err[3] = e3;
		p.rate = rate;
		p.hs = hs;
		p.last = lst;
		return p;
	endfunction

	function automatic cmd_t mk_cmd(input logic [3:0] op, input logic [7:0] rk,
		input logic [7:0] io, input logic [7:0] s1, input logic [7:0] s2, input logic [1:0] tk,
		input logic [7:0] tid, input logic [15:0] x, input logic [15:0] y);
		cmd_t c;
		c.op = op;
		c.reset_kind = rk;
		c.io_mode = io;
		c.ser1 = s1;
		c.ser2 = s2;
		c.tkind = tk;
		c.tid = tid;
		c.x = x;
		c.y = y;
		return c;
	endfunction

	function automatic row_t pred_row(input cmd_t c);
		row_t r;
		r.c = c;
		r.typed = 1'b0;
		r.typed_n = 0;
		r.typed_pkt = '0;
		return r;
	endfunction

	function automatic row_t typed_row(input cmd_t c, input int n, input pkt_t p);
		row_t r;
		r.c = c;
		r.typed = 1'b1;
		r.typed_n = n;
		r.typed_pkt = p;
		return r;
	endfunction

	// non-touch packet built from the current controller state
	function automatic pkt_t ctrl_pkt(input pkt_kind_t k, input bit with_err);
		pkt_t p;
		int i;
		p = mk_pkt(k, 8'h00, 12'h000, 12'h000, ERR_NONE, ERR_NONE, ERR_NONE, ERR_NONE,
			line_rate, hs_state, 1'b0);
		for (i = 0; i < 4; i++) begin
			if (with_err && i < ERROR_SLOT_COUNT) begin
				p.err[i] = err_slot[i];
			end
		end
		return p;
	endfunction

	// first empty slot wins, slot 0 is overwritten when all are full
	task automatic log_error(input err_code_t code);
		int i;
		bit placed;
		placed = 1'b0;
		for (i = 0; i < ERROR_SLOT_COUNT; i++) begin
			if (!placed && err_slot[i] == ERR_NONE) begin
				err_slot[i] = code;
				placed = 1'b1;
			end
		end
		if (!placed) begin
			err_slot[0] = code;
		end
		err_pend = 1'b1;
	endtask

	task automatic clear_model();
		int i;
		for (i = 0; i < ERR_PAD_COUNT; i++) begin
			err_slot[i] = ERR_NONE;
		end
		err_pend = 1'b0;
		rpt_en = 1'b0;
		line_rate = RATE_9600;
		hs_state = 1'b0;
	endtask

	task automatic predict_reply(input cmd_t c, output int n, output pkt_t p0, output pkt_t p1);
		logic [7:0] st;
		logic [2:0] rc;
		int i;
		n = 0;
		p0 = '0;
		p1 = '0;
		case (c.op)
			OP_OPEN: rpt_en = 1'b1;
			OP_QUERY_ACK: begin
				p0 = ctrl_pkt(KIND_ACK, 1'b1);
				n = 1;
				rpt_en = 1'b1;
			end
			OP_RESET: begin
				if (c.reset_kind == HARD_RESET_CODE) begin
					for (i = 0; i < ERR_PAD_COUNT; i++) begin
						err_slot[i] = ERR_NONE;
					end
				end else begin
					p0 = ctrl_pkt(KIND_RESET, 1'b0);
					n = 1;
				end
				rpt_en = 1'b1;
			end
			OP_QUERY_PARAM: begin
				p0 = ctrl_pkt(KIND_PARAM, 1'b0);
				p1 = ctrl_pkt(KIND_ACK, 1'b1);
				n = 2;
				rpt_en = 1'b1;
			end
			OP_SET_PARAM: begin
				rc = c.ser1[2:0];
				if (c.io_mode != IO_MODE_SERIAL || rc < RATE_CODE_4800) begin
					log_error(ERR_BAD_SERIAL);
				end else begin
					line_rate = 2'(rc - RATE_CODE_4800);
					if ((c.ser2 & SER2_HANDSHAKE) != 8'h00) begin
						hs_state = 1'b1;
					end
					if ((c.ser2 & SER2_RESERVED) != 8'h00) begin
						log_error(ERR_BAD_PACKET);
					end else begin
						rpt_en = 1'b1;
					end
				end
				p0 = ctrl_pkt(KIND_ACK, 1'b1);
				n = 1;
			end
			OP_SET_ACK: log_error(ERR_SET_UNAVAIL);
			OP_QUERY_RESET: log_error(ERR_QUERY_UNAVAIL);
			OP_BAD_CSUM: log_error(ERR_BAD_CHECKSUM);
			OP_TOUCH: begin
				if (rpt_en && c.tkind != TOUCH_NONE && c.tid == TOUCH_ID_MAIN) begin
					st = STATUS_BASE | (8'h01 << (c.tkind - 2'd1));
					if (err_pend) begin
						st = st | STATUS_ERRPEND;
					end
					p0 = mk_pkt(KIND_TOUCH, st, c.x[11:0], c.y[11:0], ERR_NONE, ERR_NONE,
						ERR_NONE, ERR_NONE, line_rate, hs_state, 1'b0);
					n = 1;
					err_pend = 1'b0;
				end
			end
			default: begin
				// unknown command and the undefined opcodes
				log_error(ERR_ILLEGAL_CMD);
				rpt_en = 1'b1;
			end
		endcase
		if (n == 1) begin
			p0.last = 1'b1;
		end else if (n == 2) begin
			p1.last = 1'b1;
		end
	endtask

	task automatic note_accepted(input row_t r);
		int n;
		pkt_t p0;
		pkt_t p1;
		predict_reply(r.c, n, p0, p1);
		if (r.typed) begin
			if (r.typed_n > 0) begin
				reply_q.push_back(r.typed_pkt);
			end
		end else begin
			if (n > 0) begin
				reply_q.push_back(p0);
			end
			if (n > 1) begin
				reply_q.push_back(p1);
			end
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// mostly well-formed commands and main-contact touches, the rest noise
	function automatic cmd_t rand_cmd();
		cmd_t c;
		int pick;
		c = mk_cmd(4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			2'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			c.op = OP_TOUCH;
			if ($urandom_range(0, 9) != 0) begin
				c.tid = TOUCH_ID_MAIN;
			end
		end else if (pick < 50) begin
			c.op = OP_SET_PARAM;
			if ($urandom_range(0, 9) != 0) begin
				c.io_mode = IO_MODE_SERIAL;
			end
			if ($urandom_range(0, 99) < 85) begin
				c.ser1[2:0] = 3'($urandom_range(5, 7));
			end
			if ($urandom_range(0, 3) != 0) begin
				c.ser2 = c.ser2 & ~SER2_RESERVED;
			end
		end else if (pick < 58) begin
			c.op = OP_QUERY_PARAM;
		end else if (pick < 66) begin
			c.op = OP_QUERY_ACK;
		end else if (pick < 72) begin
			c.op = OP_RESET;
			if ($urandom_range(0, 4) < 2) begin
				c.reset_kind = HARD_RESET_CODE;
			end
		end else if (pick < 76) begin
			c.op = OP_OPEN;
		end else if (pick < 80) begin
			c.op = OP_SET_ACK;
		end else if (pick < 84) begin
			c.op = OP_QUERY_RESET;
		end else if (pick < 88) begin
			c.op = OP_BAD_CSUM;
		end else if (pick < 92) begin
			c.op = OP_UNKNOWN;
		end else if (pick < 95) begin
			c.op = 4'($urandom_range(OP_FIRST_UNDEF, OP_LAST_UNDEF));
		end
		return c;
	endfunction

	task automatic load_directed();
		// touch before reporting is enabled: dropped
		dir_rows.push_back(typed_row(mk_cmd(OP_TOUCH, 8'h00, 8'h00, 8'h00, 8'h00, TOUCH_DOWN,
			TOUCH_ID_MAIN, 16'hFFFF, 16'hFFFF), 0, '0));
		dir_rows.push_back(typed_row(mk_cmd(OP_QUERY_ACK, 8'h00, 8'h00, 8'h00, 8'h00,
			TOUCH_NONE, 8'h00, 16'h0000, 16'h0000), 1, mk_pkt(KIND_ACK, 8'h00, 12'h000, 12'h000,
			ERR_NONE, ERR_NONE, ERR_NONE, ERR_NONE, RATE_9600, 1'b0, 1'b1)));
		dir_rows.push_back(typed_row(mk_cmd(OP_TOUCH, 8'h00, 8'h00, 8'h00, 8'h00, TOUCH_DOWN,
			TOUCH_ID_MAIN, 16'hFFFF, 16'h0000), 1, mk_pkt(KIND_TOUCH, 8'h81, 12'hFFF, 12'h000,
			ERR_NONE, ERR_NONE, ERR_NONE, ERR_NONE, RATE_9600, 1'b0, 1'b1)));
		dir_rows.push_back(typed_row(mk_cmd(OP_BAD_CSUM, 8'h00, 8'h00, 8'h00, 8'h00,
			TOUCH_NONE, 8'h00, 16'h0000, 16'h0000), 0, '0));
		// pending error shows in the status byte once
		dir_rows.push_back(typed_row(mk_cmd(OP_TOUCH, 8'h00, 8'h00, 8'h00, 8'h00, TOUCH_STREAM,
			TOUCH_ID_MAIN, 16'h0000, 16'hFFFF), 1, mk_pkt(KIND_TOUCH, 8'h92, 12'h000, 12'hFFF,
			ERR_NONE, ERR_NONE, ERR_NONE, ERR_NONE, RATE_9600, 1'b0, 1'b1)));
		dir_rows.push_back(typed_row(mk_cmd(OP_TOUCH, 8'h00, 8'h00, 8'h00, 8'h00, TOUCH_NONE,
			TOUCH_ID_MAIN, 16'h0123, 16'h0456), 0, '0));
		dir_rows.push_back(typed_row(mk_cmd(OP_TOUCH, 8'h00, 8'h00, 8'h00, 8'h00, TOUCH_LIFTOFF,
			8'h02, 16'h0123, 16'h0456), 0, '0));
		dir_rows.push_back(pred_row(mk_cmd(OP_TOUCH, 8'h00, 8'h00, 8'h00, 8'h00, TOUCH_LIFTOFF,
			TOUCH_ID_MAIN, 16'h1234, 16'hABCD)));
		dir_rows.push_back(pred_row(mk_cmd(OP_SET_ACK, 8'h00, 8'h00, 8'h00, 8'h00, TOUCH_NONE,
			8'h00, 16'h0000, 16'h0000)));
		dir_rows.push_back(pred_row(mk_cmd(OP_QUERY_RESET, 8'h00, 8'h00, 8'h00, 8'h00,
			TOUCH_NONE, 8'h00, 16'h0000, 16'h0000)));
		dir_rows.push_back(pred_row(mk_cmd(OP_UNKNOWN, 8'h00, 8'h00, 8'h00, 8'h00, TOUCH_NONE,
			8'h00, 16'h0000, 16'h0000)));
		// all slots full: bad serial setup overwrites slot 0
		dir_rows.push_back(typed_row(mk_cmd(OP_SET_PARAM, 8'h00, 8'h31, 8'h07, 8'h00,
			TOUCH_NONE, 8'h00, 16'h0000, 16'h0000), 1, mk_pkt(KIND_ACK, 8'h00, 12'h000, 12'h000,
			ERR_BAD_SERIAL, ERR_SET_UNAVAIL, ERR_QUERY_UNAVAIL, ERR_ILLEGAL_CMD, RATE_9600, 1'b0,
			1'b1)));
		dir_rows.push_back(pred_row(mk_cmd(OP_QUERY_PARAM, 8'h00, 8'h00, 8'h00, 8'h00,
			TOUCH_NONE, 8'h00, 16'h0000, 16'h0000)));
		dir_rows.push_back(typed_row(mk_cmd(OP_RESET, HARD_RESET_CODE, 8'h00, 8'h00, 8'h00,
			TOUCH_NONE, 8'h00, 16'h0000, 16'h0000), 0, '0));
		dir_rows.push_back(typed_row(mk_cmd(OP_QUERY_ACK, 8'h00, 8'h00, 8'h00, 8'h00,
			TOUCH_NONE, 8'h00, 16'h0000, 16'h0000), 1, mk_pkt(KIND_ACK, 8'h00, 12'h000, 12'h000,
			ERR_NONE, ERR_NONE, ERR_NONE, ERR_NONE, RATE_9600, 1'b0, 1'b1)));
		dir_rows.push_back(typed_row(mk_cmd(OP_SET_PARAM, 8'h00, IO_MODE_SERIAL, 8'hFD,
			SER2_HANDSHAKE, TOUCH_NONE, 8'h00, 16'h0000, 16'h0000), 1, mk_pkt(KIND_ACK, 8'h00,
			12'h000, 12'h000, ERR_NONE, ERR_NONE, ERR_NONE, ERR_NONE, RATE_4800, 1'b1, 1'b1)));
		// valid rate with reserved flags set: rate still taken
		dir_rows.push_back(typed_row(mk_cmd(OP_SET_PARAM, 8'h00, IO_MODE_SERIAL, 8'h07,
			SER2_RESERVED, TOUCH_NONE, 8'h00, 16'h0000, 16'h0000), 1, mk_pkt(KIND_ACK, 8'h00,
			12'h000, 12'h000, ERR_BAD_PACKET, ERR_NONE, ERR_NONE, ERR_NONE, RATE_19200, 1'b1,
			1'b1)));
		dir_rows.push_back(pred_row(mk_cmd(OP_SET_PARAM, 8'h00, IO_MODE_SERIAL, 8'h04, 8'hFF,
			TOUCH_NONE, 8'h00, 16'h0000, 16'h0000)));
		// handshake bit clear does not turn handshake off
		dir_rows.push_back(pred_row(mk_cmd(OP_SET_PARAM, 8'h00, IO_MODE_SERIAL, 8'h06, 8'h8B,
			TOUCH_NONE, 8'h00, 16'h0000, 16'h0000)));
		dir_rows.push_back(pred_row(mk_cmd(OP_RESET, 8'h31, 8'h00, 8'h00, 8'h00, TOUCH_NONE,
			8'h00, 16'h0000, 16'h0000)));
		dir_rows.push_back(pred_row(mk_cmd(OP_LAST_UNDEF, 8'h00, 8'h00, 8'h00, 8'h00,
			TOUCH_NONE, 8'h00, 16'h0000, 16'h0000)));
		dir_rows.push_back(pred_row(mk_cmd(OP_FIRST_UNDEF, 8'h00, 8'h00, 8'h00, 8'h00,
			TOUCH_NONE, 8'h00, 16'h0000, 16'h0000)));
		dir_rows.push_back(pred_row(mk_cmd(OP_OPEN, 8'h00, 8'h00, 8'h00, 8'h00, TOUCH_NONE,
			8'h00, 16'h0000, 16'h0000)));
		dir_rows.push_back(pred_row(mk_cmd(OP_TOUCH, 8'h00, 8'h00, 8'h00, 8'h00, TOUCH_DOWN,
			8'h00, 16'h0FFF, 16'h0FFF)));
		dir_rows.push_back(pred_row(mk_cmd(OP_QUERY_ACK, 8'h00, 8'h00, 8'h00, 8'h00,
			TOUCH_NONE, 8'h00, 16'h0000, 16'h0000)));
		dir_rows.push_back(pred_row(mk_cmd(OP_RESET, 8'hFF, 8'h00, 8'h00, 8'h00, TOUCH_NONE,
			8'h00, 16'h0000, 16'h0000)));
	endtask

	// offer one transaction and hold it until taken
	task automatic send_cmd(input cmd_t c, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= c.op;
		reset_kind <= c.reset_kind;
		io_mode <= c.io_mode;
		serial_one <= c.ser1;
		serial_two <= c.ser2;
		touch_kind <= c.tkind;
		touch_id <= c.tid;
		x_position <= c.x;
		y_position <= c.y;
		do begin
			@(posedge clk);
		end while (in_stall);
	endtask

	task automatic check_pkt(input pkt_t want);
		cmp_field("packet_kind", 12'(packet_kind), 12'(want.kind));
		cmp_field("status_byte", 12'(status_byte), 12'(want.status));
		cmp_field("x_out", x_out, want.x);
		cmp_field("y_out", y_out, want.y);
		cmp_field("error_zero", 12'(error_zero), 12'(want.err[0]));
		cmp_field("error_one", 12'(error_one), 12'(want.err[1]));
		cmp_field("error_two", 12'(error_two), 12'(want.err[2]));
		cmp_field("error_three", 12'(error_three), 12'(want.err[3]));
		cmp_field("rate_select", 12'(rate_select), 12'(want.rate));
		cmp_field("handshake_on", 12'(handshake_on), 12'(want.hs));
		cmp_field("last", 12'(last), 12'(want.last));
	endtask

	// receiver: random stalls, two long hold-offs, one stretch without stalls
	initial begin : sink
		int stall_left;
		int rx_cnt;
		pkt_t want;
		stall_left = 0;
		rx_cnt = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				rx_cnt++;
				if (reply_q.size() == 0) begin
					flag_mismatch("reply with nothing expected", 12'(packet_kind), 12'h000);
				end else begin
					want = reply_q.pop_front();
					check_pkt(want);
				end
				if (rx_cnt == 30 || rx_cnt == 420) begin
					stall_left = HOLD_LEN;
				end
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (rx_cnt >= 200 && rx_cnt < 320) begin
				out_stall <= 1'b0;
			end else begin
				stall_left = pick_gap();
				out_stall <= (stall_left > 0);
				if (stall_left > 0) begin
					stall_left--;
				end
			end
		end
	end

	initial begin : watchdog
		int cyc;
		cyc = 0;
		while (cyc < LIMIT_CYCLES) begin
			@(posedge clk);
			cyc++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : source
		int i;
		int w;
		cmd_t rc;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opcode <= '0;
		reset_kind <= '0;
		io_mode <= '0;
		serial_one <= '0;
		serial_two <= '0;
		touch_kind <= '0;
		touch_id <= '0;
		x_position <= '0;
		y_position <= '0;
		clear_model();
		load_directed();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k]) begin
			send_cmd(dir_rows[k].c, pick_gap());
			note_accepted(dir_rows[k]);
		end

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 300) begin
				// let the block drain completely before going on
				in_valid <= 1'b0;
				while (reply_q.size() != 0) @(posedge clk);
			end
			rc = rand_cmd();
			send_cmd(rc, (i >= 150 && i < 250) ? 0 : pick_gap());
			note_accepted(pred_row(rc));
		end
		in_valid <= 1'b0;

		for (w = 0; w < DRAIN_LIMIT && reply_q.size() != 0; w++) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (reply_q.size() != 0) begin
			flag_mismatch("replies never seen", 12'(reply_q.size()), 12'h000);
		end

		if (fail_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
